// File: sv/fsl_pkg.sv
`default_nettype none

package fsl_pkg;

    // Byte address space covered by the slots and the link memory.
    localparam int ADDR_W = 16;
    localparam int ITEM_W = 11;

    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int MAX_BLOCKS_DEF  = 16;
    localparam int CHUNK_BYTES_DEF = 8;

    localparam logic [ITEM_W-1:0] ITEM_SIZE_RST = ITEM_W'(8);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_ACK      = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] slot_address;
        logic              address_present;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } t_resp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: sv/fsl_link_ram.sv
`default_nettype none

module fsl_link_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 14
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/fixed_size_slot_free_list_core.sv
// Fixed-size slot allocator with a LIFO free list held as next-links in a link memory.
// Requests arrive on i_req_valid/o_req_ready and carry an operation (allocate, free,
// clear), a slot address and a present flag; each request yields exactly one response
// on o_resp_valid/i_resp_ready, in request order. i_cfg_we writes the slot size; the
// slot is that size rounded up to whole chunks. BLOCK_BYTES and CHUNK_BYTES must be
// powers of two; the block itself does not check this. One request is worked on at a
// time. Free, clear and unknown operations go straight to the completion state, which
// loads the response register; an allocate from the free list first waits for one
// link-memory read in the read state. An allocate on an empty list takes a fresh block,
// if one is left and the slot fits in it, and writes one link per remaining slot of it,
// one a cycle, in the fill state; otherwise it answers that the pool is exhausted. A new
// request is taken only once the block is back in idle, even while its response still
// waits in the output register; a stalled receiver holds that response, and the block
// then waits in its last state until the register frees. Reset empties the list, returns
// all blocks and sets the slot size to eight bytes; the link memory needs no clearing, as
// an entry is read only after it was written.
`default_nettype none

module fixed_size_slot_free_list_core #(
    parameter int BLOCK_BYTES = fsl_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS  = fsl_pkg::MAX_BLOCKS_DEF,
    parameter int CHUNK_BYTES = fsl_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire fsl_pkg::t_req                 i_req,
    output logic                               o_resp_valid,
    input  wire logic                          i_resp_ready,
    output fsl_pkg::t_resp                     o_resp,
    input  wire logic                          i_cfg_we,
    input  wire logic [fsl_pkg::ITEM_W-1:0]    i_cfg_wdata
);

    localparam int ADDR_W      = fsl_pkg::ADDR_W;
    localparam int WIDE_W      = ADDR_W + 2;
    localparam int CHUNK_LOG   = $clog2(CHUNK_BYTES);
    localparam int IDX_W       = ADDR_W - CHUNK_LOG;
    localparam int LINK_DEPTH  = (1 << ADDR_W) / CHUNK_BYTES;
    localparam int LINK_W      = IDX_W + 1;
    localparam int FIT_BLOCKS  = (1 << ADDR_W) / BLOCK_BYTES;
    localparam int USABLE      = (MAX_BLOCKS < FIT_BLOCKS) ? MAX_BLOCKS : FIT_BLOCKS;
    localparam int BT_W        = $clog2(USABLE + 1);
    localparam int SLOT_W      = $clog2((1 << fsl_pkg::ITEM_W) - 1 + CHUNK_BYTES);

    fsl_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]          r_head, n_head;
    logic                      r_head_valid, n_head_valid;
    logic [BT_W-1:0]           r_blocks, n_blocks;
    logic [fsl_pkg::ITEM_W-1:0] r_item_size;
    logic [ADDR_W-1:0]         r_base, n_base;
    logic [WIDE_W-1:0]         r_off, n_off;
    fsl_pkg::t_resp            r_pend, n_pend;
    fsl_pkg::t_resp            r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      w_mem_we;
    logic [IDX_W-1:0]          w_mem_waddr;
    logic [LINK_W-1:0]         w_mem_wdata;
    logic                      w_mem_re;
    logic [LINK_W-1:0]         w_mem_rdata;

    logic [SLOT_W-1:0]         w_round;
    logic [SLOT_W-1:0]         w_slot;
    logic [WIDE_W-1:0]         w_slot_w;
    logic [WIDE_W-1:0]         w_new_base;
    logic [WIDE_W-1:0]         w_first;
    logic [WIDE_W-1:0]         w_nxt;
    logic [WIDE_W-1:0]         w_here;
    logic [WIDE_W-1:0]         w_there;
    logic                      w_fits;
    logic                      w_too_big;
    logic                      w_two;
    logic                      w_accept;

    // Slot size: round up to whole chunks; a size of zero still takes one chunk.
    assign w_round  = SLOT_W'(r_item_size) + SLOT_W'(CHUNK_BYTES - 1);
    assign w_slot   = (r_item_size == '0) ? SLOT_W'(CHUNK_BYTES)
                                          : {w_round[SLOT_W-1:CHUNK_LOG], {CHUNK_LOG{1'b0}}};
    assign w_slot_w = WIDE_W'(w_slot);

    assign w_new_base = WIDE_W'(r_blocks) * WIDE_W'(BLOCK_BYTES);
    assign w_first    = w_new_base + w_slot_w;
    assign w_too_big  = w_slot_w > WIDE_W'(BLOCK_BYTES);
    assign w_two      = (w_slot_w + w_slot_w) <= WIDE_W'(BLOCK_BYTES);

    assign w_nxt   = r_off + w_slot_w;
    assign w_fits  = (w_nxt + w_slot_w) <= WIDE_W'(BLOCK_BYTES);
    assign w_here  = WIDE_W'(r_base) + r_off;
    assign w_there = WIDE_W'(r_base) + w_nxt;

    assign o_req_ready  = (r_state == fsl_pkg::S_IDLE);
    assign w_accept     = i_req_valid && o_req_ready;
    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_blocks     = r_blocks;
        n_base       = r_base;
        n_off        = r_off;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_resp_ready;
        w_mem_we     = 1'b0;
        w_mem_waddr  = '0;
        w_mem_wdata  = '0;
        w_mem_re     = 1'b0;

        unique case (r_state)
            fsl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_pend.granted_address = '0;
                    n_pend.status          = fsl_pkg::ST_ACK;
                    n_state                = fsl_pkg::S_DONE;
                    case (i_req.operation)
                        fsl_pkg::OP_ALLOC: begin
                            if (r_head_valid) begin
                                w_mem_re               = 1'b1;
                                n_pend.granted_address = {r_head, {CHUNK_LOG{1'b0}}};
                                n_pend.status          = fsl_pkg::ST_GRANTED;
                                n_state                = fsl_pkg::S_READ;
                            end else if (r_blocks >= BT_W'(USABLE) || w_too_big) begin
                                n_pend.status = fsl_pkg::ST_EXHAUSTED;
                            end else begin
                                n_pend.granted_address = ADDR_W'(w_new_base);
                                n_pend.status          = fsl_pkg::ST_GRANTED;
                                n_blocks               = r_blocks + BT_W'(1);
                                n_base                 = ADDR_W'(w_new_base);
                                n_off                  = w_slot_w;
                                // With room for a second slot, the rest of the block
                                // becomes the free list, threaded in address order.
                                if (w_two) begin
                                    n_head       = w_first[ADDR_W-1:CHUNK_LOG];
                                    n_head_valid = 1'b1;
                                    n_state      = fsl_pkg::S_FILL;
                                end
                            end
                        end
                        fsl_pkg::OP_FREE: begin
                            if (i_req.address_present) begin
                                w_mem_we     = 1'b1;
                                w_mem_waddr  = i_req.slot_address[ADDR_W-1:CHUNK_LOG];
                                w_mem_wdata  = {r_head_valid, r_head};
                                n_head       = i_req.slot_address[ADDR_W-1:CHUNK_LOG];
                                n_head_valid = 1'b1;
                            end
                        end
                        fsl_pkg::OP_CLEAR: begin
                            n_blocks     = '0;
                            n_head       = '0;
                            n_head_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fsl_pkg::S_READ: begin
                n_head       = w_mem_rdata[IDX_W-1:0];
                n_head_valid = w_mem_rdata[IDX_W];
                n_state      = fsl_pkg::S_DONE;
            end
            fsl_pkg::S_FILL: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_here[ADDR_W-1:CHUNK_LOG];
                if (w_fits) begin
                    w_mem_wdata = {1'b1, w_there[ADDR_W-1:CHUNK_LOG]};
                    n_off       = w_nxt;
                end else begin
                    w_mem_wdata = '0;
                    n_state     = fsl_pkg::S_DONE;
                end
            end
            fsl_pkg::S_DONE: begin
                if (!r_out_valid || i_resp_ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = fsl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fsl_pkg::S_IDLE;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_blocks     <= '0;
            r_item_size  <= fsl_pkg::ITEM_SIZE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_blocks     <= n_blocks;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_item_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_off  <= n_off;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    fsl_link_ram #(
        .DEPTH (LINK_DEPTH),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (r_head),
        .o_rdata (w_mem_rdata)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_req_ready)
        else $error("request accepted while another was still in progress");

    a_read_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsl_pkg::S_READ) |-> ($past(r_state) == fsl_pkg::S_IDLE))
        else $error("link read result used without a read issued");

    a_fill_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsl_pkg::S_FILL) |-> (r_off < WIDE_W'(BLOCK_BYTES)) && r_head_valid)
        else $error("block fill ran past the end of its block");

    a_free_sets_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.operation == fsl_pkg::OP_FREE && i_req.address_present)
        |=> r_head_valid)
        else $error("free left the list empty");

    a_resp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == fsl_pkg::S_DONE))
        else $error("response loaded outside the completion state");

endmodule

`default_nettype wire

// File: test/fsl_checker.sv
`default_nettype none

module fsl_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    input  wire logic                          i_req_ready,
    input  wire fsl_pkg::t_req                 i_req,
    input  wire logic                          i_resp_valid,
    input  wire logic                          i_resp_ready,
    input  wire fsl_pkg::t_resp                i_resp,
    input  wire logic                          i_cfg_we,
    input  wire logic [fsl_pkg::ITEM_W-1:0]    i_cfg_wdata,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CHUNK      = fsl_pkg::CHUNK_BYTES_DEF;
    localparam int unsigned BLOCK      = fsl_pkg::BLOCK_BYTES_DEF;
    localparam int unsigned SPACE      = 1 << fsl_pkg::ADDR_W;
    localparam int unsigned LINK_COUNT = SPACE / CHUNK;
    localparam int unsigned USABLE     = (fsl_pkg::MAX_BLOCKS_DEF < SPACE / BLOCK) ?
                                         fsl_pkg::MAX_BLOCKS_DEF : SPACE / BLOCK;

    // Shadow copy of the allocator: list head, per-chunk links and pool usage.
    logic [fsl_pkg::ITEM_W-1:0] item_size_r;
    logic [fsl_pkg::ADDR_W-1:0] head_addr;
    bit                         head_live;
    logic [fsl_pkg::ADDR_W-1:0] next_link [LINK_COUNT];
    bit                         link_live [LINK_COUNT];
    int unsigned                blocks_used;

    fsl_pkg::t_resp owed_responses[$];
    fsl_pkg::t_resp want;

    task automatic note_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_errors++;
    endtask

    function automatic int unsigned slot_span();
        int unsigned s;
        s = item_size_r;
        if (s < CHUNK)
            return CHUNK;
        if (s % CHUNK != 0)
            s += CHUNK - (s % CHUNK);
        return s;
    endfunction

    function automatic void put_link(input int unsigned at, input int unsigned nxt,
                                     input bit live);
        int unsigned idx;
        idx = (at / CHUNK) % LINK_COUNT;
        next_link[idx] = fsl_pkg::ADDR_W'(nxt);
        link_live[idx] = live;
    endfunction

    // Applies one request to the shadow state and returns the response it owes.
    function automatic fsl_pkg::t_resp apply_request(input fsl_pkg::t_req r);
        fsl_pkg::t_resp res;
        int unsigned    idx;
        int unsigned    slot;
        int unsigned    count;
        int unsigned    base;
        int unsigned    here;
        res.granted_address = '0;
        res.status          = fsl_pkg::ST_ACK;
        case (r.operation)
            fsl_pkg::OP_ALLOC: begin
                if (head_live) begin
                    res.granted_address = head_addr;
                    res.status          = fsl_pkg::ST_GRANTED;
                    idx       = (int'(head_addr) / CHUNK) % LINK_COUNT;
                    head_addr = next_link[idx];
                    head_live = link_live[idx];
                end else begin
                    slot  = slot_span();
                    count = BLOCK / slot;
                    if (blocks_used >= USABLE || count == 0) begin
                        res.status = fsl_pkg::ST_EXHAUSTED;
                    end else begin
                        base = blocks_used * BLOCK;
                        blocks_used++;
                        // The rest of the new block is threaded in address order.
                        for (int unsigned i = 1; i < count; i++) begin
                            here = base + i * slot;
                            if (i + 1 < count)
                                put_link(here, here + slot, 1'b1);
                            else
                                put_link(here, 0, 1'b0);
                        end
                        if (count > 1) begin
                            head_addr = fsl_pkg::ADDR_W'(base + slot);
                            head_live = 1'b1;
                        end
                        res.granted_address = fsl_pkg::ADDR_W'(base);
                        res.status          = fsl_pkg::ST_GRANTED;
                    end
                end
            end
            fsl_pkg::OP_FREE: begin
                if (r.address_present) begin
                    here = int'(r.slot_address) - (int'(r.slot_address) % CHUNK);
                    put_link(here, head_addr, head_live);
                    head_addr = fsl_pkg::ADDR_W'(here);
                    head_live = 1'b1;
                end
            end
            fsl_pkg::OP_CLEAR: begin
                blocks_used = 0;
                head_addr   = '0;
                head_live   = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_size_r = fsl_pkg::ITEM_SIZE_RST;
            head_addr   = '0;
            head_live   = 1'b0;
            blocks_used = 0;
            for (int k = 0; k < LINK_COUNT; k++) begin
                next_link[k] = '0;
                link_live[k] = 1'b0;
            end
            owed_responses.delete();
        end else begin
            if (i_cfg_we)
                item_size_r = i_cfg_wdata;
            if (i_resp_valid && i_resp_ready) begin
                if (owed_responses.size() == 0) begin
                    note_failure($sformatf("response 0x%0h/%0d with no request outstanding",
                                           i_resp.granted_address, i_resp.status));
                end else begin
                    want = owed_responses.pop_front();
                    if (i_resp.granted_address !== want.granted_address)
                        note_failure($sformatf("granted_address: expected 0x%0h, got 0x%0h",
                                               want.granted_address,
                                               i_resp.granted_address));
                    if (i_resp.status !== want.status)
                        note_failure($sformatf("status: expected %0d, got %0d",
                                               want.status, i_resp.status));
                end
            end
            if (i_req_valid && i_req_ready)
                owed_responses.push_back(apply_request(i_req));
        end
        o_pending = owed_responses.size();
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The block answers an undefined operation code with a plain acknowledgement.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1530;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_req_valid;
    logic                       o_req_ready;
    fsl_pkg::t_req              i_req;
    logic                       o_resp_valid;
    logic                       i_resp_ready;
    fsl_pkg::t_resp             o_resp;
    logic                       i_cfg_we;
    logic [fsl_pkg::ITEM_W-1:0] i_cfg_wdata;

    int errors;
    int pending;
    int burst_left;
    int n_sent;
    int n_settings;
    int n_granted;
    int n_exhausted;
    int n_acked;

    // Addresses granted so far, offered back as frees, now and then made misaligned.
    logic [fsl_pkg::ADDR_W-1:0] live_slots[$];

    fixed_size_slot_free_list_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    fsl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .i_resp       (o_resp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_resp_valid && i_resp_ready) begin
            case (o_resp.status)
                fsl_pkg::ST_GRANTED: begin
                    n_granted++;
                    live_slots.push_back(o_resp.granted_address);
                end
                fsl_pkg::ST_EXHAUSTED: n_exhausted++;
                default:               n_acked++;
            endcase
        end
    end

    // The receiver switches between several stall patterns of random duration.
    initial begin
        int mode;
        int span;
        i_resp_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 200);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_resp_ready = 1'b1;
                    1:       i_resp_ready = 1'($urandom_range(0, 1));
                    2:       i_resp_ready = ($urandom_range(0, 9) != 0);
                    default: i_resp_ready = ((c % 24) < 3);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so the caller must either send again or lower it at once.
    task automatic send_req(input fsl_pkg::t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_req_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_req       = r;
        i_req_valid = 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        @(negedge i_clk);
        burst_left--;
        n_sent++;
    endtask

    task automatic issue(input logic [1:0] op, input logic [fsl_pkg::ADDR_W-1:0] addr,
                         input logic present);
        fsl_pkg::t_req r;
        r.operation       = op;
        r.slot_address    = addr;
        r.address_present = present;
        if (op == fsl_pkg::OP_CLEAR)
            live_slots.delete();
        send_req(r);
    endtask

    task automatic settle();
        i_req_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_item_size(input logic [fsl_pkg::ITEM_W-1:0] v);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        n_settings++;
    endtask

    task automatic random_phase(input int count, input bit drain);
        int roll;
        int pick;
        logic [fsl_pkg::ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++) begin
            roll = drain ? $urandom_range(0, 99) * 45 / 85 : $urandom_range(0, 99);
            addr = fsl_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
            if (roll < 45) begin
                issue(fsl_pkg::OP_ALLOC, addr, 1'($urandom_range(0, 1)));
            end else if (roll < 72 && live_slots.size() != 0) begin
                pick = $urandom_range(0, live_slots.size() - 1);
                addr = live_slots[pick];
                live_slots.delete(pick);
                if ($urandom_range(0, 9) == 0)
                    addr = addr | fsl_pkg::ADDR_W'($urandom_range(1, 7));
                issue(fsl_pkg::OP_FREE, addr, 1'b1);
            end else if (roll < 80) begin
                issue(fsl_pkg::OP_FREE, addr, 1'b1);
            end else if (roll < 86) begin
                issue(fsl_pkg::OP_FREE, addr, 1'b0);
            end else if (roll < 90 && live_slots.size() != 0) begin
                // Double free: the slot stays in the pool and may be freed again.
                issue(fsl_pkg::OP_FREE,
                      live_slots[$urandom_range(0, live_slots.size() - 1)], 1'b1);
            end else if (roll < 94) begin
                issue(fsl_pkg::OP_CLEAR, addr, 1'($urandom_range(0, 1)));
            end else begin
                issue(OP_UNUSED, addr, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        int  phase;
        bit  drain;
        int  sel;
        logic [fsl_pkg::ITEM_W-1:0] size_pick;

        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        burst_left  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: null free, undefined operation, refill, misaligned and top-of-range
        // frees, clear, then the largest and smallest slot sizes.
        issue(fsl_pkg::OP_FREE, 16'hFFFF, 1'b0);
        issue(OP_UNUSED, 16'hFFFF, 1'b1);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_FREE, 16'h0003, 1'b1);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_FREE, 16'hFFFF, 1'b1);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_CLEAR, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        write_item_size(11'd2047);
        issue(fsl_pkg::OP_CLEAR, 16'hFFFF, 1'b1);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        write_item_size(11'd2040);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        write_item_size(11'd1);
        issue(fsl_pkg::OP_FREE, 16'h0000, 1'b1);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        write_item_size(11'd0);
        issue(fsl_pkg::OP_ALLOC, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_CLEAR, 16'h0000, 1'b0);
        issue(fsl_pkg::OP_ALLOC, 16'hFFFF, 1'b1);

        // Random phases. Draining phases use large slots so that the pool of
        // blocks runs out; the others mix every request kind over many sizes.
        phase = 0;
        while (n_sent < RANDOM_ITEMS + 22) begin
            drain = (phase == 0) || ($urandom_range(0, 3) == 0);
            if (drain) begin
                size_pick = fsl_pkg::ITEM_W'($urandom_range(1537, 2047));
            end else begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       size_pick = 11'd0;
                    1:       size_pick = 11'd1;
                    2:       size_pick = 11'd2040;
                    3:       size_pick = 11'd2047;
                    4:       size_pick = fsl_pkg::ITEM_W'($urandom_range(0, 2047));
                    default: size_pick = fsl_pkg::ITEM_W'($urandom_range(1, 300));
                endcase
            end
            write_item_size(size_pick);
            if (drain)
                issue(fsl_pkg::OP_CLEAR, fsl_pkg::ADDR_W'($urandom_range(0, 16'hFFFF)), 1'b0);
            random_phase(drain ? $urandom_range(50, 90) : $urandom_range(30, 120), drain);
            phase++;
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests over %0d slot-size settings.", n_sent, n_settings);
        $display("Responses: %0d grants, %0d pool exhausted, %0d plain acknowledgements.",
                 n_granted, n_exhausted, n_acked);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
